[rtl/core/urp_pkg.sv]
`timescale 1ns / 1ps

package urp_pkg;

  // Default packet size in bytes (8..127).
  localparam int PACKET_BYTES_DEF = 120;

  localparam int FILL_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int AGE_W      = 32;
  localparam int DROP_W     = 32;

  localparam logic [6:0]  LOCAL_NODE_RST = 7'd125;
  localparam logic [2:0]  PORT_NUM_RST   = 3'd1;
  localparam logic [15:0] ROUTE_TO_RST   = 16'd3000;
  localparam logic [7:0]  IDLE_FLUSH_RST = 8'd2;
  localparam logic [2:0]  PORT_MAX       = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_ROUTE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_NODE = 2'd0,
    CFG_PORT_NUM   = 2'd1,
    CFG_ROUTE_TO   = 2'd2,
    CFG_IDLE_FLUSH = 2'd3
  } cfg_reg_t;

  // Flush command from front to back.
  typedef struct packed {
    logic              bank;
    logic [FILL_W-1:0] fill;
    logic [6:0]        dest;
    logic [7:0]        proto;
    logic [2:0]        port;
    logic [DROP_W-1:0] drop;
  } flush_cmd_t;

  // Back tells front that a bank has been read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_done_t;

endpackage

[rtl/core/urp_ram.sv]
`timescale 1ns / 1ps

module urp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/urp_cmd_q.sv]
`timescale 1ns / 1ps

module urp_cmd_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  urp_pkg::flush_cmd_t din,
  output logic                valid,
  input  logic                pop,
  output urp_pkg::flush_cmd_t dout
);

  import urp_pkg::*;

  // Two entries: at most one outstanding flush per bank.
  flush_cmd_t  slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign valid  = (count != 2'd0);
  assign dout   = slot[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/core/urp_front.sv]
`timescale 1ns / 1ps

module urp_front #(
  parameter int PACKET_BYTES = urp_pkg::PACKET_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          opcode,
  input  logic [7:0]                          data_byte,
  input  logic [6:0]                          source_node,
  input  logic [6:0]                          target_node,
  input  logic signed [7:0]                   serial_select,
  input  logic [7:0]                          protocol_code,
  input  logic                                sink_ready,
  input  logic                                cfg_we,
  input  logic [urp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [urp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                ram_we,
  output logic [$clog2(PACKET_BYTES+1)-3:0]   ram_waddr,
  output logic [63:0]                         ram_wdata,
  output logic                                cmd_push,
  output urp_pkg::flush_cmd_t                 cmd,
  input  urp_pkg::bank_done_t                 done
);

  import urp_pkg::*;

  localparam int WIDX = $clog2(PACKET_BYTES + 1) - 3;
  localparam logic [FILL_W-1:0] PB_C = FILL_W'(PACKET_BYTES);

  // Configuration
  logic [6:0]  local_node;
  logic [2:0]  port_number;
  logic [15:0] route_timeout_ms;
  logic [7:0]  idle_flush_ms;

  // Item state; ages replace absolute timestamps
  logic [AGE_W-1:0]  req_age, req_age_next;
  logic [AGE_W-1:0]  byte_age, byte_age_next;
  logic              route_ok, route_ok_next;
  logic [6:0]        remote_node, remote_node_next;
  logic [7:0]        protocol_tag, protocol_tag_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [DROP_W-1:0] drop, drop_next;
  logic              wbank, wbank_next;
  logic [1:0]        busy, busy_next;
  logic [63:0]       cur_word, cur_word_next;

  logic              accept;
  logic              is_tick, is_byte, is_route;
  logic [AGE_W-1:0]  ra, ba, ba3;
  logic              expired, ok1;
  logic [FILL_W-1:0] f1, f2, f3;
  logic              pre_flush, post_flush, flush, store, drop_inc;
  logic              match;
  logic signed [7:0] sel_eff;
  logic [63:0]       merged;
  logic [1:0]        set_b, clr_b;

  assign full = busy[wbank] || (busy[~wbank] && (fill >= PB_C));

  always_comb begin
    accept   = push && !full;
    is_tick  = (opcode == OP_TICK);
    is_byte  = (opcode == OP_BYTE);
    is_route = (opcode == OP_ROUTE);

    ra      = req_age + AGE_W'(is_tick);
    ba      = byte_age + AGE_W'(is_tick);
    expired = route_ok && (ra >= AGE_W'(route_timeout_ms));
    ok1     = route_ok && !expired;
    f1      = expired ? '0 : fill;

    // full packet: try to flush before storing
    pre_flush = is_byte && ok1 && (f1 >= PB_C) && sink_ready;
    f2        = pre_flush ? '0 : f1;
    store     = is_byte && ok1 && (f2 < PB_C);
    drop_inc  = is_byte && ok1 && !store && (drop != '1);
    f3        = store ? f2 + FILL_W'(1) : f2;
    ba3       = store ? '0 : ba;

    post_flush = (is_tick || is_byte) && !pre_flush && ok1 && (f3 != '0) && sink_ready
                 && ((f3 >= PB_C) || (ba3 >= AGE_W'(idle_flush_ms)));
    flush      = pre_flush || post_flush;

    // byte lane merge; lane 0 starts a clean word
    merged = (f2[2:0] == 3'd0) ? 64'd0 : cur_word;
    merged[{f2[2:0], 3'b000} +: 8] = data_byte;

    sel_eff = (serial_select == -8'sd1) ? 8'sd1 : serial_select;
    match   = (target_node == local_node) && (sel_eff[7:3] == 5'd0)
              && (sel_eff[2:0] == port_number) && (port_number != 3'd0)
              && (port_number <= PORT_MAX);

    req_age_next      = req_age;
    byte_age_next     = byte_age;
    route_ok_next     = route_ok;
    remote_node_next  = remote_node;
    protocol_tag_next = protocol_tag;
    fill_next         = fill;
    drop_next         = drop;
    wbank_next        = wbank;
    cur_word_next     = cur_word;

    if (accept) begin
      if (is_tick || is_byte) begin
        req_age_next  = ra;
        byte_age_next = ba3;
        route_ok_next = ok1;
        fill_next     = post_flush ? '0 : f3;
        drop_next     = drop + DROP_W'(drop_inc);
        wbank_next    = wbank ^ flush;
        if (store) begin
          cur_word_next = merged;
        end
      end else if (is_route && match) begin
        remote_node_next  = source_node;
        protocol_tag_next = protocol_code;
        req_age_next      = '0;
        route_ok_next     = (source_node != 7'd0);
      end
    end

    set_b     = (accept && flush) ? (2'b01 << wbank) : 2'b00;
    clr_b     = done.valid ? (2'b01 << done.bank) : 2'b00;
    busy_next = (busy & ~clr_b) | set_b;

    ram_we    = accept && store;
    ram_waddr = {pre_flush ? ~wbank : wbank, f2[3 +: WIDX]};
    ram_wdata = merged;

    cmd_push  = accept && flush;
    cmd.bank  = wbank;
    cmd.fill  = pre_flush ? f1 : f3;
    cmd.dest  = remote_node;
    cmd.proto = protocol_tag;
    cmd.port  = port_number;
    cmd.drop  = pre_flush ? drop : drop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_node       <= LOCAL_NODE_RST;
      port_number      <= PORT_NUM_RST;
      route_timeout_ms <= ROUTE_TO_RST;
      idle_flush_ms    <= IDLE_FLUSH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LOCAL_NODE: local_node       <= cfg_data[6:0];
        CFG_PORT_NUM:   port_number      <= cfg_data[2:0];
        CFG_ROUTE_TO:   route_timeout_ms <= cfg_data[15:0];
        CFG_IDLE_FLUSH: idle_flush_ms    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_age      <= '0;
      byte_age     <= '0;
      route_ok     <= 1'b0;
      remote_node  <= '0;
      protocol_tag <= '0;
      fill         <= '0;
      drop         <= '0;
      wbank        <= 1'b0;
      busy         <= 2'b00;
    end else begin
      req_age      <= req_age_next;
      byte_age     <= byte_age_next;
      route_ok     <= route_ok_next;
      remote_node  <= remote_node_next;
      protocol_tag <= protocol_tag_next;
      fill         <= fill_next;
      drop         <= drop_next;
      wbank        <= wbank_next;
      busy         <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_word <= cur_word_next;
  end

endmodule

[rtl/core/urp_back.sv]
`timescale 1ns / 1ps

module urp_back #(
  parameter int PACKET_BYTES = urp_pkg::PACKET_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  urp_pkg::flush_cmd_t               q_cmd,
  output logic                              q_pop,
  output logic                              ram_re,
  output logic [$clog2(PACKET_BYTES+1)-3:0] ram_raddr,
  input  logic [63:0]                       ram_rdata,
  output urp_pkg::bank_done_t               done,
  output logic                              empty,
  input  logic                              pop,
  output logic [63:0]                       packet_word,
  output logic [3:0]                        word_bytes,
  output logic                              last_word,
  output logic [6:0]                        dest_node,
  output logic [7:0]                        protocol_out,
  output logic [2:0]                        port_id,
  output logic [31:0]                       dropped_total
);

  import urp_pkg::*;

  localparam int WIDX = $clog2(PACKET_BYTES + 1) - 3;

  typedef struct packed {
    logic [3:0]        nbytes;
    logic              last;
    logic [6:0]        dest;
    logic [7:0]        proto;
    logic [2:0]        port;
    logic [DROP_W-1:0] drop;
  } word_meta_t;

  typedef struct packed {
    logic [63:0] word;
    word_meta_t  meta;
  } out_item_t;

  flush_cmd_t        cmd_r;
  logic              act;
  logic [WIDX-1:0]   idx;
  logic [WIDX-1:0]   last_idx;
  logic              rd_pend;
  word_meta_t        pend;
  out_item_t         slot [2];
  logic              head;
  logic [1:0]        occ;

  logic              pop_fire;
  logic [2:0]        room;
  logic              issue;
  logic              is_last;
  logic [FILL_W-1:0] fm1;
  word_meta_t        meta_now;

  always_comb begin
    pop_fire = pop && !empty;
    room     = {1'b0, occ} + {2'b00, rd_pend} - {2'b00, pop_fire};
    issue    = act && (room < 3'd2);
    is_last  = (idx == last_idx);
    q_pop    = !act && q_valid;
    fm1      = q_cmd.fill - FILL_W'(1);

    meta_now.nbytes = (is_last && (cmd_r.fill[2:0] != 3'd0)) ? {1'b0, cmd_r.fill[2:0]}
                                                             : 4'd8;
    meta_now.last   = is_last;
    meta_now.dest   = cmd_r.dest;
    meta_now.proto  = cmd_r.proto;
    meta_now.port   = cmd_r.port;
    meta_now.drop   = cmd_r.drop;

    ram_re     = issue;
    ram_raddr  = {cmd_r.bank, idx};
    done.valid = issue && is_last;
    done.bank  = cmd_r.bank;
  end

  assign empty         = (occ == 2'd0);
  assign packet_word   = slot[head].word;
  assign word_bytes    = slot[head].meta.nbytes;
  assign last_word     = slot[head].meta.last;
  assign dest_node     = slot[head].meta.dest;
  assign protocol_out  = slot[head].meta.proto;
  assign port_id       = slot[head].meta.port;
  assign dropped_total = slot[head].meta.drop;

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r    <= q_cmd;
      idx      <= '0;
      last_idx <= fm1[3 +: WIDX];
    end else if (issue && !is_last) begin
      idx <= idx + WIDX'(1);
    end
    if (issue) begin
      pend <= meta_now;
    end
    if (rd_pend) begin
      slot[head ^ occ[0]] <= {ram_rdata, pend};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      act     <= 1'b0;
      rd_pend <= 1'b0;
      head    <= 1'b0;
      occ     <= 2'd0;
    end else begin
      if (q_pop) begin
        act <= 1'b1;
      end else if (issue && is_last) begin
        act <= 1'b0;
      end
      rd_pend <= issue;
      if (pop_fire) begin
        head <= ~head;
      end
      occ <= occ + {1'b0, rd_pend} - {1'b0, pop_fire};
    end
  end

endmodule

[rtl/core/uart_rx_packetizer_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// -------   -------------------------  ------------------------------------------
// input     push / full                opcode, data_byte, source_node, target_node,
//                                      serial_select, protocol_code, sink_ready
// result    empty / pop                packet_word, word_bytes, last_word, dest_node,
//                                      protocol_out, port_id, dropped_total
// config    cfg_we, cfg_index          cfg_data (write only, no wait)
//
// Flow: the front takes one item per cycle while full is low. A flush queues a
// command; the back reads the buffer one 64-bit word per cycle while the result queue
// has room, ceil(fill/8) words (up to 15 at 120 bytes), via the RAM read register.
// Stalls: the buffer is two banks; full is high while the back still reads the bank
// the next item would write. The result queue holds two items.
// Reset: rst is synchronous; control state clears without a clearing pass.

module uart_rx_packetizer_core #(
  parameter int PACKET_BYTES = urp_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input item
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     opcode,
  input  logic [7:0]                     data_byte,
  input  logic [6:0]                     source_node,
  input  logic [6:0]                     target_node,
  input  logic signed [7:0]              serial_select,
  input  logic [7:0]                     protocol_code,
  input  logic                           sink_ready,
  // result item
  output logic                           empty,
  input  logic                           pop,
  output logic [63:0]                    packet_word,
  output logic [3:0]                     word_bytes,
  output logic                           last_word,
  output logic [6:0]                     dest_node,
  output logic [7:0]                     protocol_out,
  output logic [2:0]                     port_id,
  output logic [31:0]                    dropped_total,
  // configuration
  input  logic                           cfg_we,
  input  logic [urp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import urp_pkg::*;

  // Word index plus bank bit addresses the packet RAM.
  localparam int AW = $clog2(PACKET_BYTES + 1) - 2;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic          cmd_push;
  flush_cmd_t    cmd_in;
  logic          q_valid;
  logic          q_pop;
  flush_cmd_t    q_cmd;
  bank_done_t    done;

  // Front: timeouts, routing, byte capture, flush decision.
  urp_front #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .source_node   (source_node),
    .target_node   (target_node),
    .serial_select (serial_select),
    .protocol_code (protocol_code),
    .sink_ready    (sink_ready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .done          (done)
  );

  // Flush commands waiting for the back.
  urp_cmd_q u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_cmd)
  );

  // Two banks of packet words, one per outstanding flush.
  urp_ram #(
    .WIDTH (64),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: reads packet words out into the result queue.
  urp_back #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .done          (done),
    .empty         (empty),
    .pop           (pop),
    .packet_word   (packet_word),
    .word_bytes    (word_bytes),
    .last_word     (last_word),
    .dest_node     (dest_node),
    .protocol_out  (protocol_out),
    .port_id       (port_id),
    .dropped_total (dropped_total)
  );

endmodule
